// ===== rtl/fba_pkg.sv =====
package fba_pkg;

   localparam int ADDR_W = 27;
   localparam int EFR_W = 15;
   localparam int OP_W = 3;
   localparam int CFG_W = 16;
   localparam int WORD_BITS = 32;
   localparam int BIT_W = 5;
   localparam int STEP_W = 4;
   localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 16'd32768;

   localparam logic [OP_W-1:0] OP_MARK_USED   = 3'd0;
   localparam logic [OP_W-1:0] OP_MARK_FREE   = 3'd1;
   localparam logic [OP_W-1:0] OP_TEST        = 3'd2;
   localparam logic [OP_W-1:0] OP_ALLOC_ENTRY = 3'd3;
   localparam logic [OP_W-1:0] OP_FREE_ENTRY  = 3'd4;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [3:0] {
      C_NONE,
      C_ALWAYS,
      C_CLR_LAST,
      C_ACCEPT,
      C_SKIP,
      C_RANGE_BAD,
      C_ALLOC,
      C_SEARCH_END,
      C_WORD_FULL,
      C_OUT_FREE
   } cond_type;

   typedef enum logic [2:0] {
      M_NONE,
      M_CLEAR,
      M_RD_TGT,
      M_WR_MOD,
      M_RD_CNT,
      M_WR_ALLOC
   } mem_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_CLR,
      CNT_INC
   } cnt_op_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_CLEAR,
      RES_RMW,
      RES_ALLOC,
      RES_FAIL
   } res_op_type;

   typedef struct packed {
      cond_type   cond;
      step_type   target;
      logic       stay;
      mem_op_type mem_op;
      cnt_op_type cnt_op;
      res_op_type res_op;
      logic       accept;
      logic       emit;
   } ctrl_type;

   typedef struct packed {
      logic clr_last;
      logic accept;
      logic skip;
      logic range_bad;
      logic is_alloc;
      logic search_end;
      logic word_full;
      logic out_free;
   } cond_flags_type;

   typedef struct packed {
      logic              is_used;
      logic [ADDR_W-1:0] alloc_address;
      logic              present;
      logic              writable;
      logic              user;
      logic [EFR_W-1:0]  frame;
      logic              changed;
      logic              failed;
   } rsp_type;

endpackage

// ===== rtl/frame_bitmap_allocator.sv =====
// Bitmap page-frame allocator, one bit per frame, held as 32-bit words in a
// single-port memory.
// req channel: one item per operation; req_tuser carries the operation and
// req_tdata the page address, entry frame, kernel mode and write flag.
// rsp channel: exactly one item for every request item.
// csr_wr_en / csr_wr_data write frame_count; the user must write it only
// while the block is idle, which the block does not enforce. After reset
// the block clears all MAX_FRAMES/32 words (1024 by default), one word a
// cycle, and holds req_tready low meanwhile. A microcoded sequencer drives
// the datapath and takes one item at a time. A no-op goes straight to the
// output, a range failure sets failed first, and mark, test or entry free
// read the target word and write it back. An allocation scans the words in
// turn, each costing one memory read and one check, then sets the first
// clear bit, or fails when all searched words are full. A new item is taken
// in the cycle after the result is loaded into the output register, which
// holds it while the receiver stalls; the sequencer waits only if it is full.
module frame_bitmap_allocator #(
   parameter int MAX_FRAMES       = 32768,
   parameter int FRAME_BYTES_LOG2 = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[2:0]
   input  logic [2:0]  req_tuser,
   // page_address[26:0], entry_frame[41:27], kernel_mode[42], writable[43]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // is_used[0], alloc_address[27:1], entry_present[28], entry_writable[29],
   // entry_user[30], new_entry_frame[45:31], entry_changed[46], failed[47]
   output logic [47:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import fba_pkg::*;

   localparam int WORD_COUNT = MAX_FRAMES / 32;
   localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int CNT_W = $clog2(WORD_COUNT + 1);
   localparam int FR_W = ADDR_W - FRAME_BYTES_LOG2;
   localparam int TF_W = (FR_W > EFR_W) ? FR_W : EFR_W;
   localparam int LIM_W = $clog2(MAX_FRAMES + 1);
   localparam int CMP_A = (TF_W > CFG_W + 1) ? TF_W : CFG_W + 1;
   localparam int CMP_W = (CMP_A > LIM_W) ? CMP_A : LIM_W;
   localparam int FW = AW + BIT_W;
   localparam int SH_W = FW + FRAME_BYTES_LOG2;

   ctrl_type       ctrl;
   cond_flags_type flags;

   logic [CFG_W-1:0]  fc_ff;
   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [EFR_W-1:0]  efr_ff;
   logic              kern_ff;
   logic              wr_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [AW-1:0]     waddr_ff;
   logic [31:0]       mem_q_ff;
   rsp_type           res_ff;
   rsp_type           out_ff;
   logic              out_valid_ff;

   logic [31:0] bitmap_mem [WORD_COUNT];

   logic              acc;
   logic [CMP_W-1:0]  fc_ext;
   logic [CMP_W-1:0]  lim;
   logic [CMP_W-1:0]  words;
   logic [TF_W-1:0]   tframe;
   logic [AW-1:0]     tgt_word;
   logic [BIT_W-1:0]  tbit;
   logic [31:0]       tmask;
   logic [31:0]       mod_word;
   logic [31:0]       q_inc;
   logic [31:0]       first_zero;
   logic [BIT_W-1:0]  zero_idx;
   logic [FW-1:0]     alloc_f;
   logic [SH_W-1:0]   alloc_sh;
   logic              mem_we;
   logic              mem_re;
   logic [AW-1:0]     mem_addr;
   logic [31:0]       mem_wdata;
   logic              emit;

   fba_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign req_tready = ctrl.accept;
   assign acc = req_tvalid & req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {out_ff.failed, out_ff.changed, out_ff.frame, out_ff.user,
                       out_ff.writable, out_ff.present, out_ff.alloc_address,
                       out_ff.is_used};

   // Managed limit is frame_count clipped to MAX_FRAMES.
   assign fc_ext = CMP_W'(fc_ff);
   assign lim = (fc_ext > CMP_W'(MAX_FRAMES)) ? CMP_W'(MAX_FRAMES) : fc_ext;
   assign words = lim >> BIT_W;

   assign tframe = (op_ff == OP_FREE_ENTRY) ? TF_W'(efr_ff)
                                            : TF_W'(addr_ff >> FRAME_BYTES_LOG2);
   assign tgt_word = AW'(tframe >> BIT_W);
   assign tbit = tframe[BIT_W-1:0];
   assign tmask = 32'd1 << tbit;

   always_comb begin
      if (op_ff == OP_MARK_USED) begin
         mod_word = mem_q_ff | tmask;
      end else if (op_ff == OP_TEST) begin
         mod_word = mem_q_ff;
      end else begin
         mod_word = mem_q_ff & ~tmask;
      end
   end

   // Adding one carries through the trailing ones, so the sum marks the
   // lowest clear bit and OR-ing it back sets exactly that bit.
   assign q_inc = mem_q_ff + 32'd1;
   assign first_zero = ~mem_q_ff & q_inc;

   always_comb begin
      zero_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (first_zero[i]) begin
            zero_idx = zero_idx | BIT_W'(i);
         end
      end
   end

   assign alloc_f = {waddr_ff, zero_idx};
   assign alloc_sh = {alloc_f, {FRAME_BYTES_LOG2{1'b0}}};

   always_comb begin
      flags.clr_last   = (cnt_ff == CNT_W'(WORD_COUNT - 1));
      flags.accept     = acc;
      flags.skip       = (op_ff > OP_FREE_ENTRY)
                      || ((op_ff == OP_ALLOC_ENTRY) && (efr_ff != '0))
                      || ((op_ff == OP_FREE_ENTRY) && (efr_ff == '0));
      flags.range_bad  = (op_ff != OP_ALLOC_ENTRY) && (CMP_W'(tframe) >= lim);
      flags.is_alloc   = (op_ff == OP_ALLOC_ENTRY);
      flags.search_end = (CMP_W'(cnt_ff) >= words);
      flags.word_full  = (mem_q_ff == 32'hffff_ffff);
      flags.out_free   = !out_valid_ff || rsp_tready;
   end

   assign emit = ctrl.emit && flags.out_free;

   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_addr = waddr_ff;
      mem_wdata = '0;
      case (ctrl.mem_op)
         M_CLEAR: begin
            mem_we = 1'b1;
            mem_addr = cnt_ff[AW-1:0];
         end
         M_RD_TGT: begin
            mem_re = 1'b1;
            mem_addr = tgt_word;
         end
         M_RD_CNT: begin
            mem_re = 1'b1;
            mem_addr = cnt_ff[AW-1:0];
         end
         M_WR_MOD: begin
            mem_we = 1'b1;
            mem_wdata = mod_word;
         end
         M_WR_ALLOC: begin
            mem_we = 1'b1;
            mem_wdata = mem_q_ff | q_inc;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= bitmap_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= FRAME_COUNT_RST;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fc_ff <= csr_wr_data;
         end
         case (ctrl.cnt_op)
            CNT_CLR: cnt_ff <= '0;
            CNT_INC: cnt_ff <= cnt_ff + CNT_W'(1);
            default: cnt_ff <= cnt_ff;
         endcase
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         op_ff <= req_tuser;
         addr_ff <= req_tdata[26:0];
         efr_ff <= req_tdata[41:27];
         kern_ff <= req_tdata[42];
         wr_ff <= req_tdata[43];
      end
      if (mem_re) begin
         waddr_ff <= mem_addr;
      end
      if (emit) begin
         out_ff <= res_ff;
      end
      case (ctrl.res_op)
         RES_CLEAR: res_ff <= '0;
         RES_RMW: begin
            res_ff.is_used <= (op_ff == OP_TEST) && mem_q_ff[tbit];
            res_ff.changed <= (op_ff == OP_FREE_ENTRY);
         end
         RES_ALLOC: begin
            res_ff.alloc_address <= ADDR_W'(alloc_sh);
            res_ff.present <= 1'b1;
            res_ff.writable <= wr_ff;
            res_ff.user <= !kern_ff;
            res_ff.frame <= EFR_W'(alloc_f);
            res_ff.changed <= 1'b1;
         end
         RES_FAIL: res_ff.failed <= 1'b1;
         default: begin
         end
      endcase
   end

`ifndef SYNTHESIS
   a_fail_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[47] && rsp_tdata[46]))
      else $error("result both failed and changed the entry");

   a_alloc_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[27:1] != '0) |-> rsp_tdata[28])
      else $error("allocated address without a present entry");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      acc |=> !req_tready)
      else $error("sequencer took a second item without working the first");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !mem_we)
      else $error("bitmap written while waiting for an item");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (ctrl.mem_op == M_RD_CNT && !flags.search_end)
         |-> (CMP_W'(cnt_ff) < CMP_W'(WORD_COUNT)))
      else $error("search read beyond the bitmap");
`endif

endmodule

// ===== rtl/fba_useq.sv =====
module fba_useq (
   input  logic                    clock,
   input  logic                    reset,
   input  fba_pkg::cond_flags_type flags,
   output fba_pkg::ctrl_type       ctrl
);
   import fba_pkg::*;

   localparam step_type S_CLR     = 4'd0;
   localparam step_type S_IDLE    = 4'd1;
   localparam step_type S_DISP    = 4'd2;
   localparam step_type S_RANGE   = 4'd3;
   localparam step_type S_ISALLOC = 4'd4;
   localparam step_type S_RD      = 4'd5;
   localparam step_type S_MOD     = 4'd6;
   localparam step_type S_SRD     = 4'd7;
   localparam step_type S_SCHK    = 4'd8;
   localparam step_type S_SSET    = 4'd9;
   localparam step_type S_FAIL    = 4'd10;
   localparam step_type S_EMIT    = 4'd11;

   // The control store. A taken condition jumps to the target; otherwise the
   // step either holds (stay) or advances by one.
   function automatic ctrl_type rom(input step_type s);
      ctrl_type w;
      w = '0;
      unique case (s)
         S_CLR: begin
            w.cond = C_CLR_LAST; w.target = S_IDLE; w.stay = 1'b1;
            w.mem_op = M_CLEAR; w.cnt_op = CNT_INC;
         end
         S_IDLE: begin
            w.cond = C_ACCEPT; w.target = S_DISP; w.stay = 1'b1;
            w.accept = 1'b1; w.cnt_op = CNT_CLR; w.res_op = RES_CLEAR;
         end
         S_DISP: begin
            w.cond = C_SKIP; w.target = S_EMIT;
         end
         S_RANGE: begin
            w.cond = C_RANGE_BAD; w.target = S_FAIL;
         end
         S_ISALLOC: begin
            w.cond = C_ALLOC; w.target = S_SRD;
         end
         S_RD: begin
            w.mem_op = M_RD_TGT;
         end
         S_MOD: begin
            w.cond = C_ALWAYS; w.target = S_EMIT;
            w.mem_op = M_WR_MOD; w.res_op = RES_RMW;
         end
         S_SRD: begin
            w.cond = C_SEARCH_END; w.target = S_FAIL;
            w.mem_op = M_RD_CNT; w.cnt_op = CNT_INC;
         end
         S_SCHK: begin
            w.cond = C_WORD_FULL; w.target = S_SRD;
         end
         S_SSET: begin
            w.cond = C_ALWAYS; w.target = S_EMIT;
            w.mem_op = M_WR_ALLOC; w.res_op = RES_ALLOC;
         end
         S_FAIL: begin
            w.res_op = RES_FAIL;
         end
         S_EMIT: begin
            w.cond = C_OUT_FREE; w.target = S_IDLE; w.stay = 1'b1;
            w.emit = 1'b1;
         end
         default: begin
            w.cond = C_ALWAYS; w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

   step_type step_ff, step_in;
   logic     hit;

   assign ctrl = rom(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         C_NONE:       hit = 1'b0;
         C_ALWAYS:     hit = 1'b1;
         C_CLR_LAST:   hit = flags.clr_last;
         C_ACCEPT:     hit = flags.accept;
         C_SKIP:       hit = flags.skip;
         C_RANGE_BAD:  hit = flags.range_bad;
         C_ALLOC:      hit = flags.is_alloc;
         C_SEARCH_END: hit = flags.search_end;
         C_WORD_FULL:  hit = flags.word_full;
         C_OUT_FREE:   hit = flags.out_free;
         default:      hit = 1'b0;
      endcase
      if (hit) begin
         step_in = ctrl.target;
      end else if (ctrl.stay) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_CLR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
